[hw/rtl/tst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the trapezoid segment time unit.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_W         = 32;   // waypoint coordinate width
    localparam int DIST_W        = 33;   // |difference| and distance width
    localparam int SQ_W          = 66;   // sum of three squares
    localparam int SUB_W         = 66;   // shared subtract/compare width
    localparam int REG_W         = 32;   // speed, accel, duration

    localparam logic [REG_W-1:0] CRUISE_RESET = 32'd196608;
    localparam logic [REG_W-1:0] ACCEL_RESET  = 32'd196608;
    localparam logic [REG_W-1:0] DUR_MAX      = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic CFG_CRUISE = 1'b0;
    localparam logic CFG_ACCEL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_ROOT,
        ST_PROD,
        ST_DIV,
        ST_ROOT2,
        ST_DONE
    } tst_state_t;

endpackage

[hw/rtl/tst_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tst_mul
    import tst_pkg::*;
(
    input  logic                clk,
    input  logic [DIST_W-1:0]   a,
    input  logic [DIST_W-1:0]   b,
    output logic [2*DIST_W-1:0] p
);

    logic [2*DIST_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

[hw/rtl/tst_sub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_sub
// Shared subtract and compare: difference and a >= b.
// ----------------------------------------------------------------------------
module tst_sub
    import tst_pkg::*;
(
    input  logic [SUB_W-1:0] a,
    input  logic [SUB_W-1:0] b,
    output logic [SUB_W-1:0] diff,
    output logic             ge
);

    logic [SUB_W:0] full;

    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[SUB_W-1:0];
    assign ge   = ~full[SUB_W];     // no borrow

endmodule

[hw/rtl/trapezoid_segment_time_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_segment_time_unit
// Travel time of a straight segment under a trapezoidal velocity profile.
// ----------------------------------------------------------------------------
// Waypoints (signed Q.F metres) come in on the slave stream; the unit keeps
// the previous one and, for each waypoint after the first of a route, sends
// one transfer with the segment time (unsigned Q.F seconds), a triangular
// flag and a saturation flag. A route start, or the first point after reset,
// is stored and gives no result. Work per segment runs on one registered
// 33x33 multiplier and one 66-bit subtract/compare unit under a sequencer:
// squares, a square root for the distance, products and compare, then a
// restoring division and, for triangular profiles, a second root, and last
// the hand-off to the output stage. The divider loop is the longest step.
// s_tready is low while this runs. A zero cruise_speed or accel_limit gives
// all ones with saturated set. The output stage holds one finished result,
// so the next waypoint is taken while it waits. Configuration writes are
// always accepted (cfg_ready high).
// ----------------------------------------------------------------------------
module trapezoid_segment_time_unit
    import tst_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // config write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [REG_W-1:0]   cfg_data,
    // waypoint stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [3*POS_W-1:0] s_tdata,    // pos_x, pos_y, pos_z
    input  logic               s_tuser,    // route_start
    // segment stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [REG_W-1:0]   m_tdata,    // seg_duration
    output logic [1:0]         m_tuser     // triangular, saturated
);

    localparam int NW     = SQ_W + FRAC_BITS;   // division numerator width
    localparam int RW     = 2 * ((NW + 1) / 2); // shift register width
    localparam int RH     = RW / 2;             // root width
    localparam int CW     = $clog2(RW + 1);
    localparam int TRI_SH = 2 * FRAC_BITS + 2;

    localparam logic [CW-1:0] SQR_LAST   = CW'(3);
    localparam logic [CW-1:0] ROOT_LAST  = CW'(DIST_W - 1);
    localparam logic [CW-1:0] PROD_LAST  = CW'(3);
    localparam logic [CW-1:0] DIV_LAST   = CW'(NW - 1);
    localparam logic [CW-1:0] ROOT2_LAST = CW'(RH - 1);

    tst_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [REG_W-1:0] cruise_reg, accel_reg;
    logic signed [POS_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic have_prev_reg;

    logic [DIST_W-1:0] dx_reg, dy_reg, dz_reg, dq_reg;
    logic [SQ_W-1:0]   acc_reg, da_reg, vv_reg;
    logic [RW-1:0]     rad_reg;
    logic [SUB_W-1:0]  rem_reg;
    logic [RH-1:0]     root_reg;
    logic [2*REG_W-1:0] den_reg;
    logic              tri_reg;
    logic [REG_W-1:0]  res_dur_reg;
    logic              res_tri_reg, res_sat_reg;

    logic              m_tvalid_reg;
    logic [REG_W-1:0]  m_dur_reg;
    logic              m_tri_reg, m_sat_reg;

    // input side
    logic signed [POS_W-1:0] in_x, in_y, in_z;
    logic signed [DIST_W-1:0] dif_x, dif_y, dif_z;
    logic in_acc, in_start, zero_reg;

    assign in_x = s_tdata[POS_W-1:0];
    assign in_y = s_tdata[2*POS_W-1:POS_W];
    assign in_z = s_tdata[3*POS_W-1:2*POS_W];

    assign dif_x = DIST_W'(in_x) - DIST_W'(prev_x_reg);
    assign dif_y = DIST_W'(in_y) - DIST_W'(prev_y_reg);
    assign dif_z = DIST_W'(in_z) - DIST_W'(prev_z_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign in_start = s_tuser | ~have_prev_reg;
    assign zero_reg = (cruise_reg == '0) | (accel_reg == '0);
    assign cfg_ready = 1'b1;

    // shared multiplier operands
    logic [DIST_W-1:0] mul_a, mul_b;
    logic [2*DIST_W-1:0] prod;

    always_comb
    begin
        mul_a = dx_reg;
        mul_b = dx_reg;
        if (state_reg == ST_SQR)
        begin
            case (cnt_reg)
                CW'(1):
                begin
                    mul_a = dy_reg;
                    mul_b = dy_reg;
                end
                CW'(2):
                begin
                    mul_a = dz_reg;
                    mul_b = dz_reg;
                end
                default:
                begin
                    mul_a = dx_reg;
                    mul_b = dx_reg;
                end
            endcase
        end
        else
        begin
            case (cnt_reg)
                CW'(0):
                begin
                    mul_a = dq_reg;
                    mul_b = DIST_W'(accel_reg);
                end
                CW'(1):
                begin
                    mul_a = DIST_W'(cruise_reg);
                    mul_b = DIST_W'(cruise_reg);
                end
                default:
                begin
                    mul_a = DIST_W'(accel_reg);
                    mul_b = DIST_W'(cruise_reg);
                end
            endcase
        end
    end

    tst_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // shared subtract/compare operands
    logic [SUB_W-1:0] sq_rem_sh, sq_trial, dv_rem_sh, sub_a, sub_b, sub_diff;
    logic             sub_ge;

    assign sq_rem_sh = {rem_reg[SUB_W-3:0], rad_reg[RW-1 -: 2]};
    assign sq_trial  = {{(SUB_W-RH-2){1'b0}}, root_reg, 2'b01};
    assign dv_rem_sh = {rem_reg[SUB_W-2:0], rad_reg[NW-1]};

    always_comb
    begin
        case (state_reg)
            ST_DIV:
            begin
                sub_a = dv_rem_sh;
                sub_b = SUB_W'(den_reg);
            end
            ST_PROD:
            begin
                sub_a = da_reg;
                sub_b = vv_reg;
            end
            default:
            begin
                sub_a = sq_rem_sh;
                sub_b = sq_trial;
            end
        endcase
    end

    tst_sub u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    logic [SQ_W-1:0] acc_sum, trap_sum;
    logic [RH-1:0]   root_new;
    logic [NW-1:0]   quot_new;
    logic            out_free;

    assign acc_sum  = acc_reg + prod;
    assign trap_sum = vv_reg + da_reg;
    assign root_new = {root_reg[RH-2:0], sub_ge};
    assign quot_new = {rad_reg[NW-2:0], sub_ge};
    assign out_free = ~m_tvalid_reg | m_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc && !in_start)
                    state_next = zero_reg ? ST_DONE : ST_SQR;
            end
            ST_SQR:
            begin
                if (cnt_reg == SQR_LAST)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_PROD;
                    cnt_next   = '0;
                end
            end
            ST_PROD:
            begin
                if (cnt_reg == PROD_LAST)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = tri_reg ? ST_ROOT2 : ST_DONE;
                    cnt_next   = '0;
                end
            end
            ST_ROOT2:
            begin
                if (cnt_reg == ROOT2_LAST)
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
            end
            ST_DONE:
            begin
                cnt_next = '0;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cruise_reg    <= CRUISE_RESET;
            accel_reg     <= ACCEL_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            have_prev_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CRUISE: cruise_reg <= cfg_data;
                    CFG_ACCEL:  accel_reg  <= cfg_data;
                    default:    ;
                endcase
            end
            if (in_acc)
            begin
                prev_x_reg    <= in_x;
                prev_y_reg    <= in_y;
                prev_z_reg    <= in_z;
                have_prev_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dx_reg  <= dif_x[DIST_W-1] ? DIST_W'(-dif_x) : DIST_W'(dif_x);
                dy_reg  <= dif_y[DIST_W-1] ? DIST_W'(-dif_y) : DIST_W'(dif_y);
                dz_reg  <= dif_z[DIST_W-1] ? DIST_W'(-dif_z) : DIST_W'(dif_z);
                acc_reg <= '0;
                res_dur_reg <= DUR_MAX;
                res_tri_reg <= 1'b0;
                res_sat_reg <= 1'b1;
            end
            ST_SQR:
            begin
                if (cnt_reg != '0)
                    acc_reg <= acc_sum;
                if (cnt_reg == SQR_LAST)
                begin
                    rad_reg  <= {acc_sum, {(RW-SQ_W){1'b0}}};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[RW-3:0], 2'b00};
                rem_reg  <= sub_ge ? sub_diff : sq_rem_sh;
                root_reg <= root_new;
                if (cnt_reg == ROOT_LAST)
                    dq_reg <= root_new[DIST_W-1:0];
            end
            ST_PROD:
            begin
                if (cnt_reg == CW'(1))
                    da_reg <= prod;
                if (cnt_reg == CW'(2))
                    vv_reg <= prod;
                if (cnt_reg == PROD_LAST)
                begin
                    // triangular when dq*a < v*v
                    tri_reg <= ~sub_ge;
                    rem_reg <= '0;
                    if (!sub_ge)
                    begin
                        rad_reg <= RW'(dq_reg) << TRI_SH;
                        den_reg <= (2*REG_W)'(accel_reg);
                    end
                    else
                    begin
                        rad_reg <= RW'(trap_sum) << FRAC_BITS;
                        den_reg <= prod[2*REG_W-1:0];
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    rad_reg  <= RW'(quot_new);
                    rem_reg  <= '0;
                    root_reg <= '0;
                    res_tri_reg <= tri_reg;
                    res_sat_reg <= |quot_new[NW-1:REG_W];
                    res_dur_reg <= (|quot_new[NW-1:REG_W]) ? DUR_MAX
                                                            : quot_new[REG_W-1:0];
                end
                else
                begin
                    rem_reg <= sub_ge ? sub_diff : dv_rem_sh;
                    rad_reg <= {rad_reg[RW-2:0], sub_ge};
                end
            end
            ST_ROOT2:
            begin
                rad_reg  <= {rad_reg[RW-3:0], 2'b00};
                rem_reg  <= sub_ge ? sub_diff : sq_rem_sh;
                root_reg <= root_new;
                if (cnt_reg == ROOT2_LAST)
                begin
                    res_sat_reg <= |root_new[RH-1:REG_W];
                    res_dur_reg <= (|root_new[RH-1:REG_W]) ? DUR_MAX
                                                            : root_new[REG_W-1:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_dur_reg <= res_dur_reg;
                    m_tri_reg <= res_tri_reg;
                    m_sat_reg <= res_sat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_dur_reg;
    assign m_tuser  = {m_sat_reg, m_tri_reg};

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trapezoid segment time unit.
// ----------------------------------------------------------------------------
// Waypoints go in on the slave stream. A scoreboard class runs its own
// fixed-point model of the segment time and keeps the expected segments in
// order. Each segment transfer from the unit is checked against the oldest
// one. Both stream sides idle at random. The run goes through several
// cruise/accel settings, including the extremes and the zero-register case.
// ----------------------------------------------------------------------------
module tb_top;
    import tst_pkg::*;

    localparam int FB      = FRAC_BITS_DEF;
    localparam int SETTLE  = 400;     // settle wait after the last segment is out
    localparam int HOLD    = 600;     // long receiver hold-off

    typedef struct packed {
        logic [REG_W-1:0] dur;
        logic             tri_f;
        logic             sat_f;
    } segment_t;

    // ------------------------------------------------------------------------
    // Scoreboard: segment time model plus queue of expected segments
    // ------------------------------------------------------------------------
    class segment_board;
        segment_t         pending_q[$];
        logic [REG_W-1:0] speed_q16;
        logic [REG_W-1:0] accel_q16;
        longint           last_x, last_y, last_z;
        bit               have_last;
        int               errors, checked, n_tri, n_sat;

        function new();
            speed_q16 = CRUISE_RESET;
            accel_q16 = ACCEL_RESET;
            last_x = 0;
            last_y = 0;
            last_z = 0;
            have_last = 0;
        endfunction

        function void set_reg(logic idx, logic [REG_W-1:0] val);
            if (idx == CFG_CRUISE)
                speed_q16 = val;
            else
                speed_q16 = speed_q16;
            if (idx == CFG_ACCEL)
                accel_q16 = val;
        endfunction

        function automatic logic [127:0] int_root(logic [127:0] n);
            logic [127:0] res, bitv;
            res  = '0;
            bitv = 128'd1 << 126;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic logic [63:0] abs_delta(longint a, longint b);
            longint d;
            d = a - b;
            return (d < 0) ? 64'(-d) : 64'(d);
        endfunction

        // accepted waypoint: update stored point, queue a segment if one is due
        function void note_waypoint(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                    logic signed [POS_W-1:0] z, logic start);
            logic [127:0] dx, dy, dz, span, vq, aq, t;
            bit           first;
            segment_t     seg;
            first = start || !have_last;
            dx = abs_delta(longint'(x), last_x);
            dy = abs_delta(longint'(y), last_y);
            dz = abs_delta(longint'(z), last_z);
            last_x = x;
            last_y = y;
            last_z = z;
            have_last = 1;
            if (first)
                return;
            vq = speed_q16;
            aq = accel_q16;
            if (vq == 0 || aq == 0)
            begin
                seg.dur = DUR_MAX;
                seg.tri_f = 0;
                seg.sat_f = 1;
            end
            else
            begin
                span = int_root(dx * dx + dy * dy + dz * dz);
                seg.tri_f = (span * aq) < (vq * vq);
                if (seg.tri_f)
                    t = int_root((span << (2 * FB + 2)) / aq);
                else
                    t = ((vq * vq + span * aq) << FB) / (aq * vq);
                seg.sat_f = t > 128'hFFFF_FFFF;
                seg.dur = seg.sat_f ? DUR_MAX : t[REG_W-1:0];
            end
            pending_q = {pending_q, seg};
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_segment(logic [REG_W-1:0] dur, logic [1:0] flags);
            segment_t exp_seg;
            if (pending_q.size() == 0)
            begin
                report("unexpected segment, duration", 64'(dur), 64'd0);
                return;
            end
            exp_seg = pending_q.pop_front();
            checked++;
            n_tri += exp_seg.tri_f;
            n_sat += exp_seg.sat_f;
            if (dur !== exp_seg.dur)
                report("seg_duration", 64'(dur), 64'(exp_seg.dur));
            if (flags[0] !== exp_seg.tri_f)
                report("triangular", 64'(flags[0]), 64'(exp_seg.tri_f));
            if (flags[1] !== exp_seg.sat_f)
                report("saturated", 64'(flags[1]), 64'(exp_seg.sat_f));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [REG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [3*POS_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [REG_W-1:0]   m_tdata;
    logic [1:0]         m_tuser;

    segment_board board;
    bit           no_idle;     // stretches without gaps or stalls
    bit           hold_req;    // ask the receiver for one long hold-off
    int           sent;
    longint       cur_x, cur_y, cur_z;

    trapezoid_segment_time_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one waypoint transfer; valid stays high if the next comes with no gap
    task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_waypoint(x, y, z, start);
        sent++;
        @(negedge clk);
    endtask

    task write_reg(logic idx, logic [REG_W-1:0] val);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // stop offering, wait for every segment, then let the sequencer settle
    task drain;
        s_tvalid <= 1'b0;
        while (board.pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // random walk: mostly small steps at many scales, some jumps and repeats
    task random_point;
        int  mode, k;
        logic start;
        mode = $urandom_range(0, 19);
        start = ($urandom_range(0, 24) == 0);
        if (mode == 0)
        begin
            cur_x = $signed($urandom());
            cur_y = $signed($urandom());
            cur_z = $signed($urandom());
        end
        else if (mode != 1)
        begin
            k = $urandom_range(0, 22);
            cur_x = $signed(32'(cur_x + $signed($urandom_range(0, 2 << k)) - (1 << k)));
            cur_y = $signed(32'(cur_y + $signed($urandom_range(0, 2 << k)) - (1 << k)));
            cur_z = $signed(32'(cur_z + $signed($urandom_range(0, 2 << k)) - (1 << k)));
        end
        send_point(32'(cur_x), 32'(cur_y), 32'(cur_z), start);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall = HOLD;
                hold_req = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            board.check_segment(m_tdata, m_tuser);
        end
    end

    initial
    begin
        #20ms;
        $display("FAIL trapezoid_segment_time_unit");
        $finish;
    end

    initial
    begin
        logic [REG_W-1:0] v, a;
        board     = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CRUISE;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        no_idle   = 0;
        hold_req  = 0;
        sent      = 0;
        cur_x = 0;
        cur_y = 0;
        cur_z = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first point with no flag, repeated point, extremes
        send_point(32'd5, 32'd6, 32'd7, 1'b0);
        send_point(32'd5, 32'd6, 32'd7, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_point(32'd0, 32'd0, 32'd0, 1'b1);
        send_point(32'h0001_0000, 32'd0, 32'd0, 1'b0);   // 1 m: triangular
        send_point(32'h000B_0000, 32'd0, 32'd0, 1'b0);   // 10 m: trapezoid
        send_point(32'h000B_0000, 32'h0000_0003, 32'd0, 1'b0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h0000_0000, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0);
        send_point(32'h0003_0000, 32'd0, 32'd0, 1'b1);
        send_point(32'h0006_0000, 32'd0, 32'd0, 1'b0);   // exactly v*v/a
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin v = CRUISE_RESET; a = ACCEL_RESET; end
                1: begin v = 32'd1; a = 32'd1; end
                2: begin v = DUR_MAX; a = DUR_MAX; end
                3: begin v = 32'd1; a = DUR_MAX; end
                4: begin v = DUR_MAX; a = 32'd1; end
                5: begin v = 32'd0; a = ACCEL_RESET; end
                6: begin v = CRUISE_RESET; a = 32'd0; end
                default:
                begin
                    v = $urandom_range(1, 32'h0010_0000);
                    a = $urandom_range(1, 32'h0010_0000);
                end
            endcase
            write_reg(CFG_CRUISE, v);
            write_reg(CFG_ACCEL, a);
            no_idle = (ph == 7);
            for (int i = 0; i < ((ph == 5 || ph == 6) ? 60 : 245); i++)
            begin
                if (ph == 1 && i == 40)
                    hold_req = 1;             // block fills and stalls input
                if (ph == 8 && i == 100)
                    drain();                  // pause until all segments out
                random_point();
            end
            drain();
        end

        $display("%0d waypoints sent, %0d segments checked (%0d triangular, %0d saturated)",
                 sent, board.checked, board.n_tri, board.n_sat);
        $display("nine speed/accel settings incl. extremes and zero registers");
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("PASS trapezoid_segment_time_unit");
        else
            $display("FAIL trapezoid_segment_time_unit");
        $finish;
    end

endmodule
